FILE: src/mppg_pkg.sv
`default_nettype none

package mppg_pkg;

	// Fixed widths of the configuration registers and of the item fields.
	localparam int PERIOD_W  = 16;
	localparam int PORT_PINS = 32;
	localparam int DUTY_W    = 17;
	localparam int Q_BITS    = 16;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [DUTY_W-1:0]   ONE_Q16      = 17'h10000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;

	typedef enum logic [0:0] {
		REG_PERIOD  = 1'b0,
		REG_CHANNEL = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		FUNC_TICK = 1'b0,
		FUNC_DUTY = 1'b1
	} func_t;

	// Contents of the input register.
	typedef struct packed {
		func_t                  func;
		logic [PORT_PINS-1:0]   pin_select;
		logic [DUTY_W-1:0]      duty;
	} item_t;

endpackage

`default_nettype wire

FILE: src/multi_pin_pwm_generator.sv
`default_nettype none

// Channel     Direction  Handshake              Payload
// ----------  ---------  ---------------------  ---------------------------
// item in     input      in_valid / in_stall    func, pin_select, duty
// result out  output     out_valid / out_stall  pin_levels
// config      input      APB psel/penable/...   period_steps, channel_pins
//
// Every item yields one result transfer: the input register loads the item,
// then the tick or the duty quantization runs and updates the pin state.
// One item is taken per cycle while in_stall is low; the single 17x16
// multiplier and per-pin compares sit between the input register and the
// pin state registers.
// Reset clears the period counter, all pin levels, enables and clear
// positions, and loads the period register with 100.
// A stalled result holds the pipeline; the input register still takes one
// more transfer while the result waits, and in_stall rises only when both
// the input register and the result are occupied.
module multi_pin_pwm_generator #(
	parameter int PIN_COUNT = 32,
	parameter int STEP_BITS = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// Item channel.
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               func,
	input  wire  [mppg_pkg::PORT_PINS-1:0]    pin_select,
	input  wire  [mppg_pkg::DUTY_W-1:0]       duty,
	// Result channel.
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [mppg_pkg::PORT_PINS-1:0]    pin_levels,
	// Configuration port.
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [mppg_pkg::APB_AW-1:0]       paddr,
	input  wire  [mppg_pkg::APB_DW-1:0]       pwdata,
	output logic [mppg_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	import mppg_pkg::*;

	localparam int PROD_W = DUTY_W + STEP_BITS;
	// Largest usable period: the counter must still reach period minus one.
	localparam logic [PERIOD_W-1:0] STEP_MAX = PERIOD_W'((1 << STEP_BITS) - 2);

	// Configuration registers.
	logic [PERIOD_W-1:0]  period_q;
	logic [PORT_PINS-1:0] channel_q;
	reg_idx_t             cfg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			channel_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PERIOD:  period_q  <= pwdata[PERIOD_W-1:0];
				REG_CHANNEL: channel_q <= pwdata[PORT_PINS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PERIOD:  prdata = APB_DW'(period_q);
			REG_CHANNEL: prdata = APB_DW'(channel_q);
			default:     prdata = '0;
		endcase
	end

	// Pipeline control. The pin state registers double as the result
	// register, so they only move when the result slot is free or taken.
	logic  valid_s1;
	item_t item_s1;
	logic  adv;

	assign adv      = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.func       <= func_t'(func);
			item_s1.pin_select <= pin_select;
			item_s1.duty       <= duty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Effective period, clamped into the range the counter can handle.
	logic [PERIOD_W-1:0]  per_clamp;
	logic [STEP_BITS-1:0] eff_s;
	logic [STEP_BITS-1:0] s_m1;

	always_comb begin
		if (period_q < PERIOD_MIN) begin
			per_clamp = PERIOD_MIN;
		end else if (period_q > STEP_MAX) begin
			per_clamp = STEP_MAX;
		end else begin
			per_clamp = period_q;
		end
	end

	assign eff_s = per_clamp[STEP_BITS-1:0];
	assign s_m1  = eff_s - STEP_BITS'(1);

	// Pin state.
	logic [STEP_BITS-1:0] position_q;
	logic [PIN_COUNT-1:0] level_q;
	logic [PIN_COUNT-1:0] hen_q;
	logic [STEP_BITS-1:0] clear_q [PIN_COUNT];

	// Only the pins that exist on the ports can belong to the channel.
	logic [PIN_COUNT-1:0] own;
	logic [PIN_COUNT-1:0] sel;

	for (genvar g = 0; g < PIN_COUNT; g++) begin : g_own
		if (g < PORT_PINS) begin : g_port
			assign own[g] = channel_q[g];
			assign sel[g] = channel_q[g] && item_s1.pin_select[g];
		end else begin : g_none
			assign own[g] = 1'b0;
			assign sel[g] = 1'b0;
		end
	end

	for (genvar g = 0; g < PORT_PINS; g++) begin : g_out
		if (g < PIN_COUNT) begin : g_pin
			assign pin_levels[g] = level_q[g];
		end else begin : g_none
			assign pin_levels[g] = 1'b0;
		end
	end

	// Tick: a position left beyond a shortened period restarts at zero.
	logic [STEP_BITS-1:0] p_cur;
	logic [STEP_BITS-1:0] p_inc;
	logic [STEP_BITS-1:0] pos_next;
	logic [PIN_COUNT-1:0] clr;
	logic [PIN_COUNT-1:0] tick_levels;

	assign p_cur    = (position_q >= eff_s) ? '0 : position_q;
	assign p_inc    = p_cur + STEP_BITS'(1);
	assign pos_next = (p_inc >= eff_s) ? '0 : p_inc;

	always_comb begin
		for (int i = 0; i < PIN_COUNT; i++) begin
			clr[i] = own[i] && (clear_q[i] < p_cur);
		end
	end

	assign tick_levels = (p_cur == '0) ? (level_q | (hen_q & own)) : (level_q & ~clr);

	// Duty quantization. With prod = d*S, d*(S-1) is prod - d, so one
	// multiplier covers both the snapping tests and the clear position.
	logic [DUTY_W-1:0]    dsat;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    full_lim;
	logic [PROD_W-1:0]    prod_m1;
	logic                 duty_zero;
	logic                 duty_full;
	logic [STEP_BITS-1:0] stop;

	assign dsat      = (item_s1.duty > ONE_Q16) ? ONE_Q16 : item_s1.duty;
	assign prod      = PROD_W'(dsat) * PROD_W'(eff_s);
	assign full_lim  = PROD_W'({s_m1, Q_BITS'(0)});
	assign prod_m1   = prod - PROD_W'(dsat);
	assign duty_zero = prod < PROD_W'(ONE_Q16);
	assign duty_full = prod > full_lim;

	always_comb begin
		if (duty_zero) begin
			stop = '0;
		end else if (duty_full) begin
			stop = s_m1;
		end else begin
			stop = prod_m1[Q_BITS +: STEP_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			level_q    <= '0;
			hen_q      <= '0;
			for (int i = 0; i < PIN_COUNT; i++) begin
				clear_q[i] <= '0;
			end
		end else if (adv) begin
			case (item_s1.func)
				FUNC_TICK: begin
					position_q <= pos_next;
					level_q    <= tick_levels;
				end
				FUNC_DUTY: begin
					hen_q <= duty_zero ? (hen_q & ~sel) : (hen_q | sel);
					for (int i = 0; i < PIN_COUNT; i++) begin
						if (sel[i]) begin
							clear_q[i] <= stop;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// A tick always leaves the counter inside the period it ran with.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.func == FUNC_TICK) |=> (position_q < $past(eff_s)))
		else $error("position left outside the period");

	// Pins outside the channel never go high.
	a_own_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> ((level_q & ~$past(level_q) & ~$past(own)) == '0))
		else $error("pin outside the channel went high");

	// A duty update never moves the pin levels.
	a_duty_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.func == FUNC_DUTY) |=> $stable(level_q))
		else $error("duty update changed pin levels");

	// The input side stalls only when both stages are full and blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
